### sv/r2y_pkg.sv
// Shared types, constants and coefficient helpers of the RGB to YUV 4:2:0 converter.
package r2y_pkg;

	// Defaults for the top-level parameters.
	localparam int R2Y_MAX_WIDTH = 4096;
	localparam int R2Y_FRAC_BITS = 16;

	// Configuration port.
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// Frame geometry.
	localparam int SIZE_W    = 14;
	localparam int ROW_W     = 12;
	localparam int ROW_LIMIT = 4096;

	// Depth of the queue between the classifier and the datapath.
	localparam int FIFO_DEPTH = 4;

	// Coefficients in units of 1/10000, rounded to fixed point at elaboration.
	localparam longint COEF_SCALE = 10000;
	localparam longint COEF_ROUND = 5000;
	localparam longint Y_R  = 2989;
	localparam longint Y_G  = 5866;
	localparam longint Y_B  = 1145;
	localparam longint CB_R = 1688;
	localparam longint CB_G = 3312;
	localparam longint CB_B = 5000;
	localparam longint CR_R = 5000;
	localparam longint CR_G = 4184;
	localparam longint CR_B = 816;
	localparam longint CHROMA_OFFSET = 128;
	localparam longint CLIP_MAX      = 255;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// Position class of a pixel inside its 2x2 chroma block.
	typedef struct packed {
		logic col_odd;
		logic row_odd;
		logic frame_last;
	} pix_class_t;

	// Magnitude of a coefficient, rounded half away from zero.
	function automatic longint qcoef(input longint num, input int frac);
		return (num * (longint'(1) << frac) + COEF_ROUND) / COEF_SCALE;
	endfunction

	// Address bits of the line store for a given maximum row width.
	function automatic int slot_bits(input int max_width);
		return ((max_width >> 1) > 1) ? $clog2(max_width >> 1) : 1;
	endfunction

endpackage

### sv/r2y_if.sv
// Valid/ready stream interfaces for RGB pixels in and YUV results out.
interface r2y_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface r2y_yuv_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma;
	logic [7:0] cb_out;
	logic [7:0] cr_out;
	logic       chroma_valid;
	logic       frame_end;

	modport source (output valid, output luma, output cb_out, output cr_out,
		output chroma_valid, output frame_end, input ready);
	modport sink (input valid, input luma, input cb_out, input cr_out,
		input chroma_valid, input frame_end, output ready);
endinterface

### sv/r2y_front.sv
// Pixel intake: size registers, column and row counters, and block position classification.
module r2y_front import r2y_pkg::*; #(
	parameter int MAX_WIDTH = R2Y_MAX_WIDTH,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int AW = slot_bits(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	r2y_pix_if.sink              pixel,
	input  logic                 q_ready,
	output logic                 push,
	output pix_t                 q_pix,
	output pix_class_t           q_cls,
	output logic [AW-1:0]        q_slot
);

	localparam logic [SIZE_W-1:0] W_HI = SIZE_W'(MAX_WIDTH & ~1);
	localparam logic [CFG_W-1:0]  H_HI = CFG_W'(ROW_LIMIT & ~1);

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [CW-1:0]     col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SIZE_W-1:0] w_even;
	logic [SIZE_W-1:0] w_eff;
	logic [CFG_W-1:0]  h_even;
	logic [CFG_W-1:0]  h_eff;
	logic [CW-1:0]     col_half;
	logic              col_end;
	logic              row_end;

	assign pixel.ready = q_ready;
	assign push        = pixel.valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(WIDTH_RESET);
			height_q <= CFG_W'(HEIGHT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Odd sizes lose their low bit, then both sizes are held to their legal range.
	always_comb begin
		w_even = SIZE_W'({width_q[CFG_W-1:1], 1'b0});
		if (w_even < SIZE_W'(2)) begin
			w_eff = SIZE_W'(2);
		end else if (w_even > W_HI) begin
			w_eff = W_HI;
		end else begin
			w_eff = w_even;
		end
		h_even = {height_q[CFG_W-1:1], 1'b0};
		if (h_even < CFG_W'(2)) begin
			h_eff = CFG_W'(2);
		end else if (h_even > H_HI) begin
			h_eff = H_HI;
		end else begin
			h_eff = h_even;
		end
	end

	assign col_end  = (SIZE_W'(col_q) + SIZE_W'(1)) >= w_eff;
	assign row_end  = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;
	assign col_half = col_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign q_pix.red        = pixel.red;
	assign q_pix.green      = pixel.green;
	assign q_pix.blue       = pixel.blue;
	assign q_cls.col_odd    = col_q[0];
	assign q_cls.row_odd    = row_q[0];
	assign q_cls.frame_last = col_end && row_end;
	assign q_slot           = col_half[AW-1:0];

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		push && q_cls.frame_last |=> col_q == '0 && row_q == '0)
		else $error("counters did not return to zero after the last pixel of a frame");

endmodule

### sv/r2y_fifo.sv
// Short queue of classified pixels between the intake and the datapath.
module r2y_fifo import r2y_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int NW = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);

	logic [WIDTH-1:0] slots_q [FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == NW'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request taken from an empty queue");

endmodule

### sv/r2y_back.sv
// Datapath: coefficient products, clipping, chroma pairing through the line store, result register.
module r2y_back import r2y_pkg::*; #(
	parameter int MAX_WIDTH = R2Y_MAX_WIDTH,
	parameter int FRAC_BITS = R2Y_FRAC_BITS,
	localparam int AW = slot_bits(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  pix_t          head_pix,
	input  pix_class_t    head_cls,
	input  logic [AW-1:0] head_slot,
	output logic          pop,
	r2y_yuv_if.source     yuv
);

	localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
	localparam int KW = FRAC_BITS + 2;
	localparam int SW = FRAC_BITS + 11;
	localparam int QW = FRAC_BITS + 8;
	localparam int PW = QW + 1;
	localparam int TW = QW + 2;

	localparam logic signed [KW-1:0] K [9] = '{
		KW'(qcoef(Y_R, FRAC_BITS)),   KW'(qcoef(Y_G, FRAC_BITS)),   KW'(qcoef(Y_B, FRAC_BITS)),
		KW'(-qcoef(CB_R, FRAC_BITS)), KW'(-qcoef(CB_G, FRAC_BITS)), KW'(qcoef(CB_B, FRAC_BITS)),
		KW'(qcoef(CR_R, FRAC_BITS)),  KW'(-qcoef(CR_G, FRAC_BITS)), KW'(-qcoef(CR_B, FRAC_BITS))
	};
	localparam logic signed [SW-1:0] OFFSET = SW'(CHROMA_OFFSET << FRAC_BITS);
	localparam logic signed [SW-1:0] TOP    = SW'(CLIP_MAX << FRAC_BITS);

	function automatic logic [QW-1:0] clip_q(input logic signed [SW-1:0] v);
		if (v < 0) begin
			return '0;
		end else if (v > TOP) begin
			return QW'(TOP);
		end
		return QW'(v);
	endfunction

	logic                 en;
	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;

	// Stage 1: nine coefficient products and the line store read.
	logic signed [SW-1:0] comp [3];
	logic signed [SW-1:0] prod [9];
	logic signed [SW-1:0] prod_s1 [9];
	pix_class_t           cls_s1;
	logic [AW-1:0]        slot_s1;
	logic [2*PW-1:0]      line_rd_s1;
	logic                 byp_s1;
	logic [2*PW-1:0]      byp_data_s1;
	logic [2*PW-1:0]      line_mem [LINE_DEPTH];

	// Stage 2: clipped per-pixel values.
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] sum_u;
	logic signed [SW-1:0] sum_v;
	logic [QW-1:0]        yq;
	logic [7:0]           luma_s2;
	logic [QW-1:0]        uq_s2;
	logic [QW-1:0]        vq_s2;
	pix_class_t           cls_s2;
	logic [AW-1:0]        slot_s2;
	logic [2*PW-1:0]      line_s2;

	// Chroma combine and line store write.
	logic [2*QW-1:0]      left_q;
	logic [PW-1:0]        pair_u;
	logic [PW-1:0]        pair_v;
	logic [TW-1:0]        tot_u;
	logic [TW-1:0]        tot_v;
	logic                 wr_en;
	logic [2*PW-1:0]      wr_data;
	logic                 chroma_hit;

	// Stage 3: result register.
	logic [7:0]           luma_s3;
	logic [7:0]           cb_s3;
	logic [7:0]           cr_s3;
	logic                 cv_s3;
	logic                 fe_s3;

	// The whole pipeline moves together; the queue in front absorbs any stall.
	assign en  = !v_s3 || yuv.ready;
	assign pop = en && head_valid;

	always_comb begin
		comp[0] = SW'($signed({1'b0, head_pix.red}));
		comp[1] = SW'($signed({1'b0, head_pix.green}));
		comp[2] = SW'($signed({1'b0, head_pix.blue}));
		for (int j = 0; j < 9; j++) begin
			prod[j] = comp[j % 3] * SW'(K[j]);
		end
	end

	assign sum_y = prod_s1[0] + prod_s1[1] + prod_s1[2];
	assign sum_u = OFFSET + prod_s1[3] + prod_s1[4] + prod_s1[5];
	assign sum_v = OFFSET + prod_s1[6] + prod_s1[7] + prod_s1[8];
	assign yq    = clip_q(sum_y);

	assign pair_u     = PW'(left_q[2*QW-1:QW]) + PW'(uq_s2);
	assign pair_v     = PW'(left_q[QW-1:0]) + PW'(vq_s2);
	assign tot_u      = TW'(line_s2[2*PW-1:PW]) + TW'(pair_u);
	assign tot_v      = TW'(line_s2[PW-1:0]) + TW'(pair_v);
	assign wr_data    = {pair_u, pair_v};
	assign wr_en      = en && v_s2 && cls_s2.col_odd && !cls_s2.row_odd;
	assign chroma_hit = cls_s2.col_odd && cls_s2.row_odd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			left_q <= '0;
		end else if (en) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s2 && !cls_s2.col_odd) begin
				left_q <= {uq_s2, vq_s2};
			end
		end
	end

	// Line store: one write from stage 2 and one read for the pixel entering stage 1.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[slot_s2] <= wr_data;
		end
		if (en) begin
			line_rd_s1 <= line_mem[head_slot];
		end
	end

	// A pair sum written in the same cycle as its read is forwarded around the store.
	always_ff @(posedge clk) begin
		if (en) begin
			byp_s1      <= wr_en && (slot_s2 == head_slot);
			byp_data_s1 <= wr_data;
			prod_s1     <= prod;
			cls_s1      <= head_cls;
			slot_s1     <= head_slot;

			luma_s2 <= yq[FRAC_BITS +: 8];
			uq_s2   <= clip_q(sum_u);
			vq_s2   <= clip_q(sum_v);
			cls_s2  <= cls_s1;
			slot_s2 <= slot_s1;
			line_s2 <= byp_s1 ? byp_data_s1 : line_rd_s1;

			luma_s3 <= luma_s2;
			cb_s3   <= chroma_hit ? tot_u[FRAC_BITS+2 +: 8] : 8'd0;
			cr_s3   <= chroma_hit ? tot_v[FRAC_BITS+2 +: 8] : 8'd0;
			cv_s3   <= chroma_hit;
			fe_s3   <= cls_s2.frame_last;
		end
	end

	assign yuv.valid        = v_s3;
	assign yuv.luma         = luma_s3;
	assign yuv.cb_out       = cb_s3;
	assign yuv.cr_out       = cr_s3;
	assign yuv.chroma_valid = cv_s3;
	assign yuv.frame_end    = fe_s3;

	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		yuv.valid && !yuv.chroma_valid |-> yuv.cb_out == 8'd0 && yuv.cr_out == 8'd0)
		else $error("chroma nonzero on a pixel that completes no block");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !yuv.ready |=> v_s3 && $stable(v_s2) && $stable(v_s1))
		else $error("pipeline moved while the result was stalled");

endmodule

### sv/rgb_to_yuv420_converter.sv
// An accepted pixel enters the queue, then passes through the three datapath stages; the last is the output register.
// Throughput: one pixel per cycle sustained while the output is ready, set by the three-stage datapath
// (products, clip, chroma combine) and one line store read plus one write per pixel.
// Reset clears the counters, the left chroma register and the pipeline, and sets the
// size registers to 640 by 480; the line store is not cleared and needs no clearing
// pass, since every entry is written on an even row before an odd row reads it.
module rgb_to_yuv420_converter import r2y_pkg::*; #(
	parameter int MAX_WIDTH = R2Y_MAX_WIDTH,
	parameter int FRAC_BITS = R2Y_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	r2y_pix_if.sink              pixel,
	r2y_yuv_if.source            yuv
);

	localparam int AW = slot_bits(MAX_WIDTH);
	localparam int DW = $bits(pix_t) + $bits(pix_class_t) + AW;

	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	pix_t          f_pix;
	pix_class_t    f_cls;
	logic [AW-1:0] f_slot;
	pix_t          h_pix;
	pix_class_t    h_cls;
	logic [AW-1:0] h_slot;
	logic [DW-1:0] q_wdata;
	logic [DW-1:0] q_rdata;

	r2y_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel    (pixel),
		.q_ready  (!q_full),
		.push     (push),
		.q_pix    (f_pix),
		.q_cls    (f_cls),
		.q_slot   (f_slot)
	);

	assign q_wdata = {f_pix, f_cls, f_slot};
	assign {h_pix, h_cls, h_slot} = q_rdata;

	r2y_fifo #(
		.WIDTH(DW)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (pop),
		.empty (q_empty),
		.rdata (q_rdata)
	);

	r2y_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(!q_empty),
		.head_pix  (h_pix),
		.head_cls  (h_cls),
		.head_slot (h_slot),
		.pop       (pop),
		.yuv       (yuv)
	);

endmodule

### tb/tb_top.sv
// Self-checking testbench for the RGB to YUV 4:2:0 converter with a bit-exact pixel predictor.
`timescale 1ns / 100ps

module tb_top;
	import r2y_pkg::*;

	localparam int     FRAC        = R2Y_FRAC_BITS;
	localparam int     LINE_SLOTS  = R2Y_MAX_WIDTH / 2;
	localparam int     LATENCY_PAD = 8;
	localparam int     STALL_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 400000;

	localparam longint ONE_Q      = longint'(1) << FRAC;
	localparam longint OFFSET_Q   = 128 * ONE_Q;
	localparam longint CLIP_TOP_Q = 255 * ONE_Q;
	// Coefficient magnitudes in Q format, rounded half away from zero.
	localparam longint Q_Y_R  = (2989 * ONE_Q + 5000) / 10000;
	localparam longint Q_Y_G  = (5866 * ONE_Q + 5000) / 10000;
	localparam longint Q_Y_B  = (1145 * ONE_Q + 5000) / 10000;
	localparam longint Q_CB_R = (1688 * ONE_Q + 5000) / 10000;
	localparam longint Q_CB_G = (3312 * ONE_Q + 5000) / 10000;
	localparam longint Q_CB_B = (5000 * ONE_Q + 5000) / 10000;
	localparam longint Q_CR_R = (5000 * ONE_Q + 5000) / 10000;
	localparam longint Q_CR_G = (4184 * ONE_Q + 5000) / 10000;
	localparam longint Q_CR_B = (816 * ONE_Q + 5000) / 10000;

	// Six 2x2 frames: contrast, pure red, pure blue, yellow, cyan, and mixed values.
	localparam pix_t CORNER_PIXELS [24] = '{
		24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
		24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000,
		24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF,
		24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00,
		24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF,
		24'h00FF00, 24'hFF00FF, 24'h808080, 24'hFE017F
	};

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] cb_out;
		logic [7:0] cr_out;
		logic       chroma_valid;
		logic       frame_end;
	} yuv_result_t;

	typedef struct packed {
		bit [24:0] cb_sum;
		bit [24:0] cr_sum;
	} chroma_sums_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 pix_valid = 1'b0;
	pix_t                 pix_data  = '0;
	logic                 yuv_ready = 1'b0;

	r2y_pix_if pix_bus ();
	r2y_yuv_if yuv_bus ();

	assign pix_bus.valid = pix_valid;
	assign pix_bus.red   = pix_data.red;
	assign pix_bus.green = pix_data.green;
	assign pix_bus.blue  = pix_data.blue;
	assign yuv_bus.ready = yuv_ready;

	rgb_to_yuv420_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pix_bus),
		.yuv       (yuv_bus)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predictor state: size registers as written, counters and chroma history.
	logic [CFG_W-1:0] width_reg  = CFG_W'(WIDTH_RESET);
	logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RESET);
	logic [11:0]      col_cnt    = '0;
	logic [11:0]      row_cnt    = '0;
	logic [23:0]      left_cb    = '0;
	logic [23:0]      left_cr    = '0;
	chroma_sums_t     line_sums [LINE_SLOTS];

	pix_t        pending_pixels [$];
	yuv_result_t expected_yuv [$];

	int     sender_idle_pct   = 0;
	int     receiver_idle_pct = 0;
	int     stall_requests    = 0;
	int     stall_served      = 0;
	int     stall_left        = 0;
	int     fail_count        = 0;
	int     pixels_checked    = 0;
	int     chroma_blocks     = 0;
	int     frames_seen       = 0;
	int     size_writes       = 0;
	int     input_stall_run   = 0;
	int     input_stall_max   = 0;
	longint cycle_count       = 0;

	function automatic longint clip_q(input longint v);
		if (v < 0)
			return 0;
		if (v > CLIP_TOP_Q)
			return CLIP_TOP_Q;
		return v;
	endfunction

	function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
		int s;
		s = int'(v) & ~1;
		if (s < 2)
			s = 2;
		if (s > (hi & ~1))
			s = hi & ~1;
		return s;
	endfunction

	function automatic yuv_result_t convert_pixel(input pix_t p);
		longint      r, g, b, yq, uq, vq, su, sv;
		int          w, h, slot;
		yuv_result_t res;
		r = longint'(p.red);
		g = longint'(p.green);
		b = longint'(p.blue);
		w = clamp_size(width_reg, R2Y_MAX_WIDTH);
		h = clamp_size(height_reg, ROW_LIMIT);
		yq = clip_q(r * Q_Y_R + g * Q_Y_G + b * Q_Y_B);
		uq = clip_q(OFFSET_Q - r * Q_CB_R - g * Q_CB_G + b * Q_CB_B);
		vq = clip_q(OFFSET_Q + r * Q_CR_R - g * Q_CR_G - b * Q_CR_B);
		slot = (int'(col_cnt) >> 1) % LINE_SLOTS;
		res = '0;
		res.luma = 8'(yq >> FRAC);
		if (!col_cnt[0]) begin
			left_cb = 24'(uq);
			left_cr = 24'(vq);
		end else if (!row_cnt[0]) begin
			line_sums[slot].cb_sum = 25'(longint'(left_cb) + uq);
			line_sums[slot].cr_sum = 25'(longint'(left_cr) + vq);
		end else begin
			su = longint'(line_sums[slot].cb_sum) + longint'(left_cb) + uq;
			sv = longint'(line_sums[slot].cr_sum) + longint'(left_cr) + vq;
			res.cb_out = 8'(su >> (FRAC + 2));
			res.cr_out = 8'(sv >> (FRAC + 2));
			res.chroma_valid = 1'b1;
		end
		// A counter at or past a limit that shrank mid-frame wraps like the last pixel.
		if (int'(col_cnt) + 1 >= w) begin
			col_cnt = '0;
			if (int'(row_cnt) + 1 >= h) begin
				row_cnt = '0;
				res.frame_end = 1'b1;
			end else begin
				row_cnt = row_cnt + 1'b1;
			end
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
		return res;
	endfunction

	function automatic logic [7:0] random_component();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++)
			pending_pixels.push_back(pix_t'({random_component(), random_component(),
				random_component()}));
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || pix_valid || expected_yuv.size() != 0)
			@(negedge clk);
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FRAME_WIDTH)
			width_reg = CFG_W'(value);
		else
			height_reg = CFG_W'(value);
		size_writes++;
		@(negedge clk);
	endtask

	// Whole frames of random size, so that every odd row follows an even row of its width.
	task automatic run_random_frames(input int target);
		int done;
		int n;
		done = 0;
		while (done < target) begin
			if ($urandom_range(0, 2) != 0)
				write_size_reg(CFG_FRAME_WIDTH, $urandom_range(1, 16));
			if ($urandom_range(0, 2) != 0)
				write_size_reg(CFG_FRAME_HEIGHT, $urandom_range(0, 9));
			n = clamp_size(width_reg, R2Y_MAX_WIDTH) * clamp_size(height_reg, ROW_LIMIT);
			push_random(n);
			done += n;
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			fail_count++;
		end
	endtask

	// Pixel driver; the predictor runs on every accepted request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix_data  <= '0;
		end else begin
			if (pix_valid && pix_bus.ready)
				expected_yuv.push_back(convert_pixel(pix_data));
			if (pix_valid && !pix_bus.ready) begin
				input_stall_run <= input_stall_run + 1;
				if (input_stall_run + 1 > input_stall_max)
					input_stall_max <= input_stall_run + 1;
			end else begin
				input_stall_run <= 0;
			end
			if (!pix_valid || pix_bus.ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					pix_valid <= 1'b1;
					pix_data  <= pending_pixels.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Result ready, with an occasional long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yuv_ready  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			yuv_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_requests != stall_served) begin
			yuv_ready    <= 1'b0;
			stall_served <= stall_requests;
			stall_left   <= STALL_CYCLES;
		end else begin
			yuv_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		yuv_result_t want;
		if (arst_n && yuv_bus.valid && yuv_ready) begin
			if (expected_yuv.size() == 0) begin
				$error("result with no pixel outstanding");
				fail_count++;
			end else begin
				want = expected_yuv.pop_front();
				check_field("luma", want.luma, yuv_bus.luma);
				check_field("cb_out", want.cb_out, yuv_bus.cb_out);
				check_field("cr_out", want.cr_out, yuv_bus.cr_out);
				check_field("chroma_valid", 8'(want.chroma_valid), 8'(yuv_bus.chroma_valid));
				check_field("frame_end", 8'(want.frame_end), 8'(yuv_bus.frame_end));
				pixels_checked++;
				if (want.chroma_valid)
					chroma_blocks++;
				if (want.frame_end)
					frames_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_yuv.size());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_idle_pct   = 34;
		receiver_idle_pct = 65;
		write_size_reg(CFG_FRAME_WIDTH, 2);
		write_size_reg(CFG_FRAME_HEIGHT, 2);
		foreach (CORNER_PIXELS[i])
			pending_pixels.push_back(CORNER_PIXELS[i]);
		// Zero and odd register values round down to an even size of at least two.
		write_size_reg(CFG_FRAME_WIDTH, 0);
		write_size_reg(CFG_FRAME_HEIGHT, 3);
		push_random(4);
		write_size_reg(CFG_FRAME_WIDTH, 7);
		write_size_reg(CFG_FRAME_HEIGHT, 1);
		push_random(12);
		// Width shrinks in the middle of an even row: column 6 is past the new limit.
		write_size_reg(CFG_FRAME_WIDTH, 8);
		write_size_reg(CFG_FRAME_HEIGHT, 8);
		push_random(38);
		write_size_reg(CFG_FRAME_WIDTH, 4);
		push_random(13);
		// Height shrinks while the row counter already sits beyond the new limit.
		push_random(20);
		write_size_reg(CFG_FRAME_HEIGHT, 2);
		push_random(4);
		run_random_frames(200);

		wait_idle();
		sender_idle_pct   = 65;
		receiver_idle_pct = 34;
		// All ones in the width register gives the widest row; part of the first row
		// goes through before the width shrinks and column 40 ends the row.
		write_size_reg(CFG_FRAME_WIDTH, 8191);
		write_size_reg(CFG_FRAME_HEIGHT, 2);
		push_random(40);
		write_size_reg(CFG_FRAME_WIDTH, 4);
		push_random(5);
		run_random_frames(100);

		wait_idle();
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		// All ones in the height register gives the tallest frame; the receiver holds off
		// while its first rows are offered, and the frame is cut short after row 32.
		write_size_reg(CFG_FRAME_WIDTH, 2);
		write_size_reg(CFG_FRAME_HEIGHT, 8191);
		push_random(64);
		stall_requests++;
		write_size_reg(CFG_FRAME_HEIGHT, 2);
		push_random(2);
		run_random_frames(60);

		wait_idle();
		$display("Run covered %0d pixels, %0d chroma blocks and %0d frames over %0d size writes.",
			pixels_checked, chroma_blocks, frames_seen, size_writes);
		$display("Longest input back-pressure seen: %0d cycles.", input_stall_max);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d mismatches found", fail_count);
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

### files.f
sv/r2y_pkg.sv
sv/r2y_if.sv
sv/r2y_front.sv
sv/r2y_fifo.sv
sv/r2y_back.sv
sv/rgb_to_yuv420_converter.sv
tb/tb_top.sv
